>>> design/rcdc_pkg.sv
// ----------------------------------------------------------------------------
// rcdc_pkg: shared types and constants
// Payload structs, register indexes and arithmetic widths of the 3x3 filter.
// ----------------------------------------------------------------------------
package rcdc_pkg;

  typedef struct packed {
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic        frame_last;
    logic [11:0] pixel_y;
    logic [10:0] pixel_x;
    logic [7:0]  blue_out;
    logic [7:0]  green_out;
    logic [7:0]  red_out;
  } pix_out_t;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COEF_MID = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIVISOR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 3'd5;

  localparam int unsigned Taps = 9;
  localparam int unsigned ProdW = 25;  // 9-bit signed sample x 16-bit coef
  localparam int unsigned SumW = 30;   // nine products
  localparam logic [7:0] PixMax = 8'd255;

  typedef logic signed [15:0] coef_t;
  typedef coef_t [Taps-1:0] coef_set_t;
  typedef logic [Taps-1:0][7:0] chan_win_t;

endpackage

>>> design/rgb_convolution_3x3_div_clamp.sv
// No result for a border pixel; an interior result passes through read, window shift,
// products, sum, clamp check, 8 divide steps when a lane divides, merge and the output
// register before it is valid.
// One item at a time: the next is taken once the block is idle again, after the read for a
// border pixel and after the merge for an interior one, later while a result waits on out_stall_i.
// Reset: counters, window and configuration return to defaults; line stores are not cleared.
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_div_clamp: streaming 3x3 RGB filter
// Line stores, 3x3 window, three channel lanes and a merging output register.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3_div_clamp #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned COEF_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rcdc_pkg::pix_in_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rcdc_pkg::pix_out_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rcdc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rcdc_pkg::CfgDataW-1:0]    cfg_data_i
);
  import rcdc_pkg::*;

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WEW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HEW = $clog2(MAX_HEIGHT + 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_HOLD} top_state_e;

  top_state_e state_q;
  logic [47:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic [15:0] divisor_q;
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic [XW-1:0] col_q;
  logic [YW-1:0] row_q;
  logic [23:0] px_q;
  logic [23:0] win_q [Taps];
  logic        start_q;
  logic [2:0]  done_seen_q;
  logic [10:0] meta_x_q;
  logic [11:0] meta_y_q;
  logic        meta_last_q;
  logic        out_valid_q;
  pix_out_t    out_q;

  logic [23:0] above1, above2;
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [WEW-1:0] x_inc;
  logic [HEW-1:0] y_inc;
  logic [15:0] div_eff;
  logic [47:0] coef_rows [3];
  coef_set_t   coef_set;
  chan_win_t   chan_win [3];
  logic [2:0]  lane_done;
  logic [7:0]  lane_res [3];
  logic        accept, out_free;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (32'(width_q) < 32'd3) begin
      w_eff = WEW'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(width_q);
    end
    if (32'(height_q) < 32'd3) begin
      h_eff = HEW'(3);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(height_q);
    end
    x_inc   = WEW'(col_q) + WEW'(1);
    y_inc   = HEW'(row_q) + HEW'(1);
    div_eff = (divisor_q == 16'd0) ? 16'd1 : divisor_q;
  end

  // coefficient slots: sign-extend the low COEF_BITS of each 16-bit slot
  assign coef_rows[0] = coef_top_q;
  assign coef_rows[1] = coef_mid_q;
  assign coef_rows[2] = coef_bot_q;

  for (genvar r = 0; r < 3; r++) begin : g_coef_row
    for (genvar c = 0; c < 3; c++) begin : g_coef_col
      logic signed [COEF_BITS-1:0] raw;
      assign raw = coef_rows[r][16*c +: COEF_BITS];
      assign coef_set[r*3+c] = 16'(raw);
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    for (genvar t = 0; t < Taps; t++) begin : g_tap
      assign chan_win[ch][t] = win_q[t][8*ch +: 8];
    end
    rcdc_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (start_q),
      .smp_i    (chan_win[ch]),
      .coef_i   (coef_set),
      .divisor_i(div_eff),
      .done_o   (lane_done[ch]),
      .result_o (lane_res[ch])
    );
  end

  // row y-1 lives in store a, row y-2 in store b
  rcdc_line_store #(.DEPTH(MAX_WIDTH), .WIDTH(24)) u_store_a (
    .clk_i    (clk_i),
    .wr_en_i  (state_q == S_READ),
    .wr_addr_i(col_q),
    .wr_data_i(px_q),
    .rd_en_i  (accept),
    .rd_addr_i(col_q),
    .rd_data_o(above1)
  );

  rcdc_line_store #(.DEPTH(MAX_WIDTH), .WIDTH(24)) u_store_b (
    .clk_i    (clk_i),
    .wr_en_i  (state_q == S_READ),
    .wr_addr_i(col_q),
    .wr_data_i(above1),
    .rd_en_i  (accept),
    .rd_addr_i(col_q),
    .rd_data_o(above2)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= in_data_i;
    end
    if (state_q == S_READ) begin
      meta_x_q    <= 11'(XW'(col_q - XW'(1)));
      meta_y_q    <= 12'(YW'(row_q - YW'(1)));
      meta_last_q <= (x_inc == w_eff) && (y_inc == h_eff);
    end
    if (state_q == S_HOLD && out_free) begin
      out_q.red_out    <= lane_res[0];
      out_q.green_out  <= lane_res[1];
      out_q.blue_out   <= lane_res[2];
      out_q.pixel_x    <= meta_x_q;
      out_q.pixel_y    <= meta_y_q;
      out_q.frame_last <= meta_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      coef_top_q  <= 48'd0;
      coef_mid_q  <= 48'd65536;
      coef_bot_q  <= 48'd0;
      divisor_q   <= 16'd1;
      width_q     <= 12'd2048;
      height_q    <= 13'd4096;
      col_q       <= '0;
      row_q       <= '0;
      start_q     <= 1'b0;
      done_seen_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < Taps; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      start_q <= (state_q == S_READ) && (32'(col_q) >= 32'd2) && (32'(row_q) >= 32'd2);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_COEF_TOP: coef_top_q <= cfg_data_i;
          REG_COEF_MID: coef_mid_q <= cfg_data_i;
          REG_COEF_BOT: coef_bot_q <= cfg_data_i;
          REG_DIVISOR:  divisor_q  <= cfg_data_i[15:0];
          REG_WIDTH:    width_q    <= cfg_data_i[11:0];
          REG_HEIGHT:   height_q   <= cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (state_q == S_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          for (int r = 0; r < 3; r++) begin
            win_q[r*3]   <= win_q[r*3+1];
            win_q[r*3+1] <= win_q[r*3+2];
          end
          win_q[2] <= above2;
          win_q[5] <= above1;
          win_q[8] <= px_q;
          if (x_inc >= w_eff) begin
            col_q <= '0;
            row_q <= (y_inc >= h_eff) ? '0 : YW'(y_inc);
          end else begin
            col_q <= XW'(x_inc);
          end
          if (32'(col_q) >= 32'd2 && 32'(row_q) >= 32'd2) begin
            done_seen_q <= '0;
            state_q     <= S_CALC;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_CALC: begin
          // lanes finish at different times; collect each done pulse
          if (&(done_seen_q | lane_done)) begin
            state_q <= S_HOLD;
          end else begin
            done_seen_q <= done_seen_q | lane_done;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/rcdc_line_store.sv
// ----------------------------------------------------------------------------
// rcdc_line_store: single-port-write, registered-read line memory
// Holds one image row of packed RGB pixels.
// ----------------------------------------------------------------------------
module rcdc_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/rcdc_lane.sv
// ----------------------------------------------------------------------------
// rcdc_lane: one color channel of the filter
// Nine products, one sum, then clamp and an 8-step restoring divide.
// ----------------------------------------------------------------------------
module rcdc_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rcdc_pkg::chan_win_t smp_i,
  input  rcdc_pkg::coef_set_t coef_i,
  input  logic [15:0]       divisor_i,
  output logic              done_o,
  output logic [7:0]        result_o
);
  import rcdc_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_SUM, L_CHK, L_DIV} lane_state_e;

  lane_state_e state_q;
  logic signed [ProdW-1:0] prod_q [Taps];
  logic signed [SumW-1:0]  sum_q;
  logic [23:0]             rem_q;
  logic [22:0]             den_q;
  logic [2:0]              step_q;
  logic [7:0]              res_q;
  logic                    done_q;

  logic signed [ProdW-1:0] prod_d [Taps];
  logic signed [SumW-1:0]  sum_d;
  logic [23:0]             lim;

  always_comb begin
    for (int i = 0; i < Taps; i++) begin
      prod_d[i] = ProdW'(signed'({1'b0, smp_i[i]}) * coef_i[i]);
    end
    sum_d = '0;
    for (int i = 0; i < Taps; i++) begin
      sum_d = sum_d + SumW'(prod_q[i]);
    end
    lim = {divisor_i, 8'd0};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == L_IDLE && start_i) begin
      for (int i = 0; i < Taps; i++) begin
        prod_q[i] <= prod_d[i];
      end
    end
    if (state_q == L_SUM) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      res_q   <= '0;
      rem_q   <= '0;
      den_q   <= '0;
      step_q  <= '0;
    end else begin
      // one-cycle pulse when the clamp check or the last divide step finishes
      done_q <= ((state_q == L_CHK) && ((sum_q <= 0) || (sum_q >= SumW'(lim)))) ||
                ((state_q == L_DIV) && (step_q == 3'd0));
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            state_q <= L_SUM;
          end
        end
        L_SUM: state_q <= L_CHK;
        L_CHK: begin
          // negative or zero quotient clamps low, large quotient clamps high
          if (sum_q <= 0) begin
            res_q   <= '0;
            state_q <= L_IDLE;
          end else if (sum_q >= SumW'(lim)) begin
            res_q   <= PixMax;
            state_q <= L_IDLE;
          end else begin
            rem_q   <= sum_q[23:0];
            den_q   <= {divisor_i, 7'd0};
            step_q  <= 3'd7;
            res_q   <= '0;
            state_q <= L_DIV;
          end
        end
        L_DIV: begin
          if (rem_q >= 24'(den_q)) begin
            rem_q <= rem_q - 24'(den_q);
            res_q <= {res_q[6:0], 1'b1};
          end else begin
            res_q <= {res_q[6:0], 1'b0};
          end
          den_q  <= den_q >> 1;
          step_q <= step_q - 3'd1;
          if (step_q == 3'd0) begin
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
